// ===== rtl/lsag_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsag_pkg
// Shared types, constants and the color wheel for the LED strip animation
// generator.
// ----------------------------------------------------------------------------
package lsag_pkg;

    localparam int MAX_LEDS       = 64;
    localparam int QUEUE_DEPTH    = 2;
    localparam int PADDR_W        = 4;
    localparam int PDATA_W        = 32;
    localparam int S_TDATA_W      = 32;
    localparam int M_TDATA_W      = 40;

    localparam logic [7:0] BREATH_STEP = 8'd5;
    localparam logic [7:0] LEVEL_FULL  = 8'd255;
    localparam logic [7:0] WHEEL_SEG   = 8'd85;
    localparam logic [2:0] CHASE_LAST  = 3'd5;

    typedef enum logic [1:0]
    {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } op_t;

    typedef enum logic [7:0]
    {
        MODE_RAINBOW   = 8'd0,
        MODE_CHASE     = 8'd1,
        MODE_BREATH    = 8'd2,
        MODE_ALTERNATE = 8'd3
    } mode_t;

    typedef enum logic [1:0]
    {
        REG_LED_COUNT = 2'd0,
        REG_ANIM_MODE = 2'd1,
        REG_PERIOD    = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0]
    {
        FK_RAINBOW   = 2'd0,
        FK_CHASE     = 2'd1,
        FK_BREATH    = 2'd2,
        FK_ALTERNATE = 2'd3
    } frame_kind_t;

    typedef enum logic
    {
        RK_PIXEL  = 1'b0,
        RK_LEVEL  = 1'b1
    } result_kind_t;

    typedef struct packed
    {
        logic [6:0]  led_count;
        logic [7:0]  anim_mode;
        logic [15:0] frame_period_ms;
    } cfg_t;

    typedef struct packed
    {
        frame_kind_t kind;
        logic [6:0]  count;
        logic [7:0]  arg;
    } frame_cmd_t;

    typedef struct packed
    {
        logic       push;
        logic       pop;
        frame_cmd_t data;
    } queue_ctl_t;

    typedef struct packed
    {
        logic       full;
        logic       empty;
        frame_cmd_t head;
    } queue_stat_t;

    typedef struct packed
    {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    function automatic rgb_t color_wheel(input logic [7:0] pos);
        logic [7:0] p;
        logic [7:0] q;
        logic [9:0] t;
        rgb_t       c;
        p = LEVEL_FULL - pos;
        if (p < WHEEL_SEG)
        begin
            q = p;
        end
        else if (p < {WHEEL_SEG[6:0], 1'b0})
        begin
            q = p - WHEEL_SEG;
        end
        else
        begin
            q = p - {WHEEL_SEG[6:0], 1'b0};
        end
        t = {2'b00, q} + {1'b0, q, 1'b0};
        if (p < WHEEL_SEG)
        begin
            c.red   = LEVEL_FULL - t[7:0];
            c.green = 8'd0;
            c.blue  = t[7:0];
        end
        else if (p < {WHEEL_SEG[6:0], 1'b0})
        begin
            c.red   = 8'd0;
            c.green = t[7:0];
            c.blue  = LEVEL_FULL - t[7:0];
        end
        else
        begin
            c.red   = t[7:0];
            c.green = LEVEL_FULL - t[7:0];
            c.blue  = 8'd0;
        end
        return c;
    endfunction

endpackage

// ===== rtl/lsag_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsag_front
// Accepts events, runs the frame timer and per-mode phase state, and queues
// one frame command per fired frame (none for zero LEDs outside breath).
// ----------------------------------------------------------------------------
module lsag_front
    import lsag_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output frame_cmd_t           q_data
);

    logic        running_reg,  running_next;
    logic [31:0] last_reg,     last_next;
    logic [7:0]  offset_reg,   offset_next;
    logic [2:0]  chase_reg,    chase_next;
    logic [7:0]  level_reg,    level_next;
    logic        rising_reg,   rising_next;
    logic        alt_reg,      alt_next;

    logic        accept;
    logic [31:0] elapsed;
    logic        due;
    logic [6:0]  n_leds;
    logic        n_zero;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign elapsed  = s_tdata - last_reg;
    assign due      = elapsed >= {16'd0, cfg.frame_period_ms};
    assign n_leds   = (cfg.led_count > 7'(MAX_LEDS)) ? 7'(MAX_LEDS) : cfg.led_count;
    assign n_zero   = n_leds == 7'd0;

    always_comb
    begin
        running_next = running_reg;
        last_next    = last_reg;
        offset_next  = offset_reg;
        chase_next   = chase_reg;
        level_next   = level_reg;
        rising_next  = rising_reg;
        alt_next     = alt_reg;
        q_push       = 1'b0;
        q_data.kind  = FK_RAINBOW;
        q_data.count = n_leds;
        q_data.arg   = offset_reg;
        if (accept)
        begin
            unique case (s_tuser)
                OP_START:
                begin
                    running_next = 1'b1;
                    last_next    = s_tdata;
                end
                OP_STOP:
                begin
                    running_next = 1'b0;
                end
                OP_TICK:
                begin
                    if (running_reg && due)
                    begin
                        last_next = s_tdata;
                        unique case (cfg.anim_mode)
                            MODE_RAINBOW:
                            begin
                                q_push      = !n_zero;
                                q_data.kind = FK_RAINBOW;
                                q_data.arg  = offset_reg;
                                offset_next = offset_reg + 8'd1;
                            end
                            MODE_CHASE:
                            begin
                                q_push      = !n_zero;
                                q_data.kind = FK_CHASE;
                                q_data.arg  = {5'd0, chase_reg};
                                chase_next  = (chase_reg == CHASE_LAST) ? 3'd0
                                                                        : chase_reg + 3'd1;
                            end
                            MODE_BREATH:
                            begin
                                if (rising_reg)
                                begin
                                    if (level_reg >= LEVEL_FULL - BREATH_STEP)
                                    begin
                                        level_next  = LEVEL_FULL;
                                        rising_next = 1'b0;
                                    end
                                    else
                                    begin
                                        level_next = level_reg + BREATH_STEP;
                                    end
                                end
                                else
                                begin
                                    if (level_reg <= BREATH_STEP)
                                    begin
                                        level_next  = 8'd0;
                                        rising_next = 1'b1;
                                    end
                                    else
                                    begin
                                        level_next = level_reg - BREATH_STEP;
                                    end
                                end
                                q_push       = 1'b1;
                                q_data.kind  = FK_BREATH;
                                q_data.count = 7'd1;
                                q_data.arg   = level_next;
                            end
                            MODE_ALTERNATE:
                            begin
                                alt_next    = !alt_reg;
                                q_push      = !n_zero;
                                q_data.kind = FK_ALTERNATE;
                                q_data.arg  = {7'd0, !alt_reg};
                            end
                            default:
                            begin
                                running_next = 1'b0;
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            last_reg    <= 32'd0;
            offset_reg  <= 8'd0;
            chase_reg   <= 3'd0;
            level_reg   <= 8'd0;
            rising_reg  <= 1'b1;
            alt_reg     <= 1'b0;
        end
        else
        begin
            running_reg <= running_next;
            last_reg    <= last_next;
            offset_reg  <= offset_next;
            chase_reg   <= chase_next;
            level_reg   <= level_next;
            rising_reg  <= rising_next;
            alt_reg     <= alt_next;
        end
    end

endmodule

// ===== rtl/lsag_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsag_fifo
// Short frame command queue between the front and back parts. DEPTH is a
// power of two, at least 2.
// ----------------------------------------------------------------------------
module lsag_fifo
    import lsag_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  queue_ctl_t  ctl,
    output queue_stat_t stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_cmd_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = cnt_reg == CNT_W'(DEPTH);
    assign stat.empty = cnt_reg == '0;
    assign stat.head  = mem_reg[rd_ptr_reg];
    assign do_push    = ctl.push && !stat.full;
    assign do_pop     = ctl.pop && !stat.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= ctl.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/lsag_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsag_back
// Takes frame commands from the queue and emits one result per cycle into
// a registered output stage whenever that stage is free to take it.
// ----------------------------------------------------------------------------
module lsag_back
    import lsag_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  frame_cmd_t           q_head,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // pixel_index, red, green, blue, global_level
    output logic                 m_tuser,    // result_kind
    output logic                 m_tlast
);

    logic                 busy_reg,   busy_next;
    frame_cmd_t           cmd_reg,    cmd_next;
    logic [5:0]           idx_reg,    idx_next;
    logic [2:0]           mod6_reg,   mod6_next;
    logic                 valid_reg,  valid_next;
    logic [M_TDATA_W-1:0] data_reg,   data_next;
    logic                 kind_reg,   kind_next;
    logic                 last_reg,   last_next;

    logic                 out_free;
    logic                 emit;
    logic                 is_last;
    rgb_t                 wheel;
    rgb_t                 pix;
    logic                 alt_red;

    assign out_free = !valid_reg || m_tready;
    assign q_pop    = !busy_reg && !q_empty;
    assign emit     = busy_reg && out_free;
    assign is_last  = ({1'b0, idx_reg} + 7'd1) == cmd_reg.count;
    assign wheel    = color_wheel(8'({2'b00, idx_reg} + cmd_reg.arg));
    assign alt_red  = !idx_reg[0] == cmd_reg.arg[0];

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

    always_comb
    begin
        unique case (cmd_reg.kind)
            FK_RAINBOW:
            begin
                pix = wheel;
            end
            FK_CHASE:
            begin
                pix.red   = (mod6_reg == cmd_reg.arg[2:0]) ? LEVEL_FULL : 8'd0;
                pix.green = 8'd0;
                pix.blue  = 8'd0;
            end
            FK_ALTERNATE:
            begin
                pix.red   = alt_red ? LEVEL_FULL : 8'd0;
                pix.green = 8'd0;
                pix.blue  = alt_red ? 8'd0 : LEVEL_FULL;
            end
            default:
            begin
                pix = '0;
            end
        endcase
    end

    always_comb
    begin
        busy_next  = busy_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        mod6_next  = mod6_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        if (q_pop)
        begin
            busy_next = 1'b1;
            cmd_next  = q_head;
            idx_next  = 6'd0;
            mod6_next = 3'd0;
        end
        if (emit)
        begin
            valid_next = 1'b1;
            last_next  = is_last;
            if (cmd_reg.kind == FK_BREATH)
            begin
                kind_next = RK_LEVEL;
                data_next = {2'b00, cmd_reg.arg, 30'd0};
            end
            else
            begin
                kind_next = RK_PIXEL;
                data_next = {2'b00, 8'd0, pix.blue, pix.green, pix.red, idx_reg};
            end
            idx_next  = idx_reg + 6'd1;
            mod6_next = (mod6_reg == CHASE_LAST) ? 3'd0 : mod6_reg + 3'd1;
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        idx_reg  <= idx_next;
        mod6_reg <= mod6_next;
        data_reg <= data_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== rtl/led_strip_animation_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_animation_generator_top
// LED strip animation engine: event front end, frame queue, result emitter.
//
//   Channel   Direction  Signals                          Carries
//   s_*       in         s_tvalid/s_tready/s_tdata/user   now_ms; operation
//   m_*       out        m_tvalid/m_tready/m_tdata/user   pixel/level; result_kind, last
//   p*        in/out     APB psel/penable/pwrite/...      led_count, anim_mode, period
//
// An event is taken whenever the frame queue has room.
// A fired frame yields led_count results saturated at MAX_LEDS (none for zero,
// one for breath), one per cycle while the output is free, after the queue load.
// Output stalls fill the output register, then the queue, then hold s_tready low.
// Reset is immediate; there is no clearing pass.
// ----------------------------------------------------------------------------
module led_strip_animation_generator_top
    import lsag_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // now_ms
    input  logic [1:0]           s_tuser,    // operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // pixel_index, red, green, blue, global_level
    output logic                 m_tuser,    // result_kind
    output logic                 m_tlast,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    cfg_t        cfg_reg, cfg_next;
    logic        wr_en;
    reg_idx_t    reg_sel;
    queue_ctl_t  q_ctl;
    queue_stat_t q_stat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_LED_COUNT: cfg_next.led_count       = pwdata[6:0];
                REG_ANIM_MODE: cfg_next.anim_mode       = pwdata[7:0];
                REG_PERIOD:    cfg_next.frame_period_ms = pwdata[15:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_LED_COUNT: prdata = {25'd0, cfg_reg.led_count};
            REG_ANIM_MODE: prdata = {24'd0, cfg_reg.anim_mode};
            REG_PERIOD:    prdata = {16'd0, cfg_reg.frame_period_ms};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.led_count       <= 7'd1;
            cfg_reg.anim_mode       <= MODE_RAINBOW;
            cfg_reg.frame_period_ms <= 16'd100;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lsag_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_stat.full),
        .q_push   (q_ctl.push),
        .q_data   (q_ctl.data)
    );

    lsag_fifo #(.DEPTH(DEPTH)) u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (q_ctl),
        .stat  (q_stat)
    );

    lsag_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_stat.empty),
        .q_head   (q_stat.head),
        .q_pop    (q_ctl.pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/lsag_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsag_checker
// Port-level checks on the result stream and the register port.
// ----------------------------------------------------------------------------
module lsag_checker
    import lsag_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser,
    input  logic                 m_tlast,
    input  logic                 pready
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    a_level_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("brightness transfer not last of frame");

    a_level_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[29:0] == 30'd0)
        else $error("brightness transfer carries pixel data");

    a_pixel_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[39:30] == 10'd0 && m_tdata[13:6] == 8'd0
                                 || m_tvalid && !m_tuser && m_tdata[39:30] == 10'd0
                                    && m_tdata[21:14] == 8'd0
                                 || m_tvalid && !m_tuser && m_tdata[39:30] == 10'd0
                                    && m_tdata[29:22] == 8'd0)
        else $error("pixel transfer malformed");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("register port not ready");

endmodule

bind led_strip_animation_generator_top lsag_checker u_lsag_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .pready   (pready)
);
